### hw/rtl/tcpt_pkg.sv
// tcpt_pkg: shared types and codes of the tcp connection tracker
`timescale 1ns / 1ps
`default_nettype none
package tcpt_pkg;

    localparam int SESSIONS_DEF = 64;

    localparam logic [2:0] EV_IGNORED  = 3'd0;
    localparam logic [2:0] EV_ADDED    = 3'd1;
    localparam logic [2:0] EV_MODIFIED = 3'd2;
    localparam logic [2:0] EV_REMOVED  = 3'd3;
    localparam logic [2:0] EV_DUP_SYN  = 3'd4;
    localparam logic [2:0] EV_BAD_SYN  = 3'd5;
    localparam logic [2:0] EV_FULL     = 3'd6;

    localparam logic [1:0] ST_DISC          = 2'd0;
    localparam logic [1:0] ST_CONNECTING    = 2'd1;
    localparam logic [1:0] ST_CONNECTED     = 2'd2;
    localparam logic [1:0] ST_DISCONNECTING = 2'd3;

    localparam logic [1:0] MK_NONE = 2'd0;
    localparam logic [1:0] MK_SYN  = 2'd1;
    localparam logic [1:0] MK_FIN  = 2'd2;

    localparam logic [1:0] CL_NONE      = 2'd0;
    localparam logic [1:0] CL_INITIATOR = 2'd1;
    localparam logic [1:0] CL_RESPONDER = 2'd2;

    localparam logic [2:0] LK_NONE      = 3'd0;
    localparam logic [2:0] LK_SYNACK    = 3'd1;
    localparam logic [2:0] LK_HS_ACK    = 3'd2;
    localparam logic [2:0] LK_FIRST_FIN = 3'd3;
    localparam logic [2:0] LK_SECOND_FIN = 3'd4;
    localparam logic [2:0] LK_FINAL_ACK = 3'd5;

    typedef struct packed {
        logic [31:0] sip;
        logic [15:0] sport;
        logic [31:0] dip;
        logic [15:0] dport;
    } t_key;

    typedef struct packed {
        logic [1:0]  state;
        logic [1:0]  imark;
        logic [1:0]  rmark;
        logic [1:0]  closer;
        logic [47:0] last;
    } t_status;

    typedef struct packed {
        t_key        key;
        logic        syn;
        logic        fin;
        logic        rst;
        logic        ack;
        logic [47:0] arrival;
        logic        fwd_hit;
        t_status     fwd;
        logic        rev_hit;
        t_status     rev;
        logic        free_hit;
    } t_probe;

    typedef struct packed {
        logic    en;
        logic    valid;
        logic    load_key;
        t_key    key;
        t_status st;
    } t_wr;

endpackage
`default_nettype wire

### hw/rtl/tcpt_if.sv
// tcpt_if: packet summary and result channels of the tcp connection tracker
`timescale 1ns / 1ps
`default_nettype none
interface tcpt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic        fin_flag;
    logic        rst_flag;
    logic        ack_flag;
    logic [47:0] arrival_time;

    modport source (output valid, source_ip, source_port, dest_ip, dest_port,
                    syn_flag, fin_flag, rst_flag, ack_flag, arrival_time,
                    input ready);
    modport sink (input valid, source_ip, source_port, dest_ip, dest_port,
                  syn_flag, fin_flag, rst_flag, ack_flag, arrival_time,
                  output ready);
endinterface

interface tcpt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic        reverse_dir;
    logic [5:0]  slot_index;
    logic [1:0]  conn_state_out;
    logic [2:0]  latency_kind;
    logic [47:0] latency_us;

    modport source (output valid, event_code, reverse_dir, slot_index, conn_state_out,
                    latency_kind, latency_us, input ready);
    modport sink (input valid, event_code, reverse_dir, slot_index, conn_state_out,
                  latency_kind, latency_us, output ready);
endinterface
`default_nettype wire

### hw/rtl/tcpt_cell.sv
// tcpt_cell: one session slot; checks the passing lookup item and takes write-backs
`timescale 1ns / 1ps
`default_nettype none
module tcpt_cell #(
    parameter int SLOT_W = 6,
    parameter int IDX    = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_vld,
    input  tcpt_pkg::t_probe      i_probe,
    input  wire  [SLOT_W-1:0]     i_fwd_slot,
    input  wire  [SLOT_W-1:0]     i_rev_slot,
    input  wire  [SLOT_W-1:0]     i_free_slot,
    input  tcpt_pkg::t_wr         i_wr,
    input  wire  [SLOT_W-1:0]     i_wr_slot,
    output logic                  o_vld,
    output tcpt_pkg::t_probe      o_probe,
    output logic [SLOT_W-1:0]     o_fwd_slot,
    output logic [SLOT_W-1:0]     o_rev_slot,
    output logic [SLOT_W-1:0]     o_free_slot
);
    import tcpt_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic        r_valid;
    t_key        r_key;
    t_status     r_st;
    logic        r_vld;
    t_probe      r_probe, n_probe;
    logic [SLOT_W-1:0] r_fwd_slot, n_fwd_slot, r_rev_slot, n_rev_slot;
    logic [SLOT_W-1:0] r_free_slot, n_free_slot;
    logic        fwd_match, rev_match;

    assign fwd_match = r_valid && r_key.sip == i_probe.key.sip
                    && r_key.sport == i_probe.key.sport
                    && r_key.dip == i_probe.key.dip && r_key.dport == i_probe.key.dport;
    assign rev_match = r_valid && r_key.sip == i_probe.key.dip
                    && r_key.sport == i_probe.key.dport
                    && r_key.dip == i_probe.key.sip && r_key.dport == i_probe.key.sport;

    // lowest slot wins: earlier cells already set the hit flags
    always_comb begin
        n_probe     = i_probe;
        n_fwd_slot  = i_fwd_slot;
        n_rev_slot  = i_rev_slot;
        n_free_slot = i_free_slot;
        if (!i_probe.fwd_hit && fwd_match) begin
            n_probe.fwd_hit = 1'b1;
            n_probe.fwd     = r_st;
            n_fwd_slot      = MY_SLOT;
        end
        if (!i_probe.rev_hit && rev_match) begin
            n_probe.rev_hit = 1'b1;
            n_probe.rev     = r_st;
            n_rev_slot      = MY_SLOT;
        end
        if (!i_probe.free_hit && !r_valid) begin
            n_probe.free_hit = 1'b1;
            n_free_slot      = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_wr.en && i_wr_slot == MY_SLOT) begin
                r_valid <= i_wr.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe     <= n_probe;
        r_fwd_slot  <= n_fwd_slot;
        r_rev_slot  <= n_rev_slot;
        r_free_slot <= n_free_slot;
        if (i_wr.en && i_wr_slot == MY_SLOT) begin
            r_st <= i_wr.st;
            if (i_wr.load_key) begin
                r_key <= i_wr.key;
            end
        end
    end

    assign o_vld       = r_vld;
    assign o_probe     = r_probe;
    assign o_fwd_slot  = r_fwd_slot;
    assign o_rev_slot  = r_rev_slot;
    assign o_free_slot = r_free_slot;
endmodule
`default_nettype wire

### hw/rtl/tcp_connection_tracker.sv
// tcp_connection_tracker: session table as a chain of slot cells plus update logic
//
// i_pkt carries one tcp packet summary per item (valid/ready); o_res returns
// exactly one result item per packet, in order.
// A lookup item walks the chain of SESSIONS cells, one cell per cycle, and
// collects the first forward match, the first reverse match and the first
// free slot. When it leaves the chain the update is decided and written back
// to the chosen cell in the same cycle the result is registered.
// One packet is in flight at a time: a new packet is taken only once the
// previous one has walked the whole cell chain and its result is registered.
// A new packet may be accepted while the previous result still waits.
// When o_res is stalled a finished lookup waits, and no further packet is
// taken until the result register frees up.
// Synchronous reset clears all slot valid bits and the control state; the
// block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_tracker #(
    parameter int SESSIONS = tcpt_pkg::SESSIONS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tcpt_in_if.sink    i_pkt,
    tcpt_out_if.source o_res
);
    import tcpt_pkg::*;

    localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_fsm, n_fsm;
    logic        accept, fire;

    logic        c_vld [SESSIONS+1];
    t_probe      c_probe [SESSIONS+1];
    logic [SLOT_W-1:0] c_fwd [SESSIONS+1];
    logic [SLOT_W-1:0] c_rev [SESSIONS+1];
    logic [SLOT_W-1:0] c_free [SESSIONS+1];
    t_probe      probe_in;

    t_probe      r_fin;
    logic [SLOT_W-1:0] r_fwd_slot, r_rev_slot, r_free_slot;

    t_wr         wr;
    logic [SLOT_W-1:0] wr_slot;

    logic        r_out_vld;
    logic [2:0]  r_ev, n_ev;
    logic        r_rev, n_rev;
    logic [5:0]  r_slot, n_slot;
    logic [1:0]  r_cst, n_cst;
    logic [2:0]  r_kind, n_kind;
    logic [47:0] r_lat, n_lat;

    assign accept = i_pkt.valid && i_pkt.ready;
    assign i_pkt.ready = (r_fsm == S_IDLE) && i_rst_n;
    assign fire = (r_fsm == S_DONE) && (!r_out_vld || o_res.ready);

    always_comb begin
        probe_in         = '0;
        probe_in.key     = '{sip: i_pkt.source_ip, sport: i_pkt.source_port,
                             dip: i_pkt.dest_ip, dport: i_pkt.dest_port};
        probe_in.syn     = i_pkt.syn_flag;
        probe_in.fin     = i_pkt.fin_flag;
        probe_in.rst     = i_pkt.rst_flag;
        probe_in.ack     = i_pkt.ack_flag;
        probe_in.arrival = i_pkt.arrival_time;
    end

    assign c_vld[0]   = accept;
    assign c_probe[0] = probe_in;
    assign c_fwd[0]   = '0;
    assign c_rev[0]   = '0;
    assign c_free[0]  = '0;

    for (genvar g = 0; g < SESSIONS; g++) begin : g_cell
        tcpt_cell #(.SLOT_W(SLOT_W), .IDX(g)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_vld       (c_vld[g]),
            .i_probe     (c_probe[g]),
            .i_fwd_slot  (c_fwd[g]),
            .i_rev_slot  (c_rev[g]),
            .i_free_slot (c_free[g]),
            .i_wr        (wr),
            .i_wr_slot   (wr_slot),
            .o_vld       (c_vld[g+1]),
            .o_probe     (c_probe[g+1]),
            .o_fwd_slot  (c_fwd[g+1]),
            .o_rev_slot  (c_rev[g+1]),
            .o_free_slot (c_free[g+1])
        );
    end

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            S_IDLE:  if (accept) n_fsm = S_RUN;
            S_RUN:   if (c_vld[SESSIONS]) n_fsm = S_DONE;
            S_DONE:  if (fire) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    // update decision on the finished lookup
    logic              hit, rev;
    t_status           st, ns;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        own, other, my_side;
    logic [47:0]       lat;
    logic [SLOT_W+5:0] slot_ext;

    always_comb begin
        hit     = r_fin.fwd_hit || r_fin.rev_hit;
        rev     = !r_fin.fwd_hit && r_fin.rev_hit;
        st      = r_fin.fwd_hit ? r_fin.fwd : r_fin.rev;
        slot    = r_fin.fwd_hit ? r_fwd_slot : r_rev_slot;
        own     = rev ? st.rmark : st.imark;
        other   = rev ? st.imark : st.rmark;
        my_side = rev ? CL_RESPONDER : CL_INITIATOR;
        lat     = (r_fin.arrival > st.last) ? r_fin.arrival - st.last : 48'd0;
        ns      = st;

        wr          = '0;
        wr.key      = r_fin.key;
        wr_slot     = slot;
        n_ev        = EV_IGNORED;
        n_rev       = rev;
        n_kind      = LK_NONE;
        n_lat       = '0;
        n_cst       = st.state;

        if (!hit) begin
            // no session: open one (handshake start or mid-stream), or report a full table
            n_rev = 1'b0;
            if (r_fin.free_hit) begin
                wr_slot     = r_free_slot;
                wr.en       = 1'b1;
                wr.valid    = 1'b1;
                wr.load_key = 1'b1;
                wr.st.state = r_fin.syn ? ST_CONNECTING : ST_CONNECTED;
                wr.st.imark = MK_SYN;
                wr.st.rmark = r_fin.syn ? MK_NONE : MK_SYN;
                wr.st.closer = CL_NONE;
                wr.st.last  = r_fin.arrival;
                n_ev        = EV_ADDED;
                n_cst       = wr.st.state;
            end else begin
                wr_slot = '0;
                n_ev    = EV_FULL;
                n_cst   = ST_DISC;
            end
        end else if (r_fin.syn) begin
            if (own == MK_SYN) begin
                n_ev = EV_DUP_SYN;
            end else if (!rev) begin
                wr.en    = 1'b1;
                wr.valid = 1'b0;
                wr.st    = st;
                n_ev     = EV_BAD_SYN;
                n_cst    = ST_DISC;
            end else begin
                ns.rmark = MK_SYN;
                ns.last  = r_fin.arrival;
                wr.en    = 1'b1;
                wr.valid = 1'b1;
                wr.st    = ns;
                n_ev     = EV_MODIFIED;
                n_kind   = LK_SYNACK;
                n_lat    = lat;
            end
        end else if (r_fin.fin) begin
            if (own != MK_FIN) begin
                if (rev) ns.rmark = MK_FIN;
                else     ns.imark = MK_FIN;
                if (st.state == ST_CONNECTED) begin
                    ns.state = ST_DISCONNECTING;
                    if (st.closer == CL_NONE) ns.closer = my_side;
                end
                ns.last  = r_fin.arrival;
                wr.en    = 1'b1;
                wr.valid = 1'b1;
                wr.st    = ns;
                n_ev     = EV_MODIFIED;
                n_kind   = (other == MK_SYN) ? LK_FIRST_FIN : LK_SECOND_FIN;
                n_lat    = lat;
                n_cst    = ns.state;
            end
        end else if (r_fin.rst) begin
            wr.en    = 1'b1;
            wr.valid = 1'b0;
            wr.st    = st;
            n_ev     = EV_REMOVED;
            n_kind   = LK_FIRST_FIN;
            n_lat    = lat;
            n_cst    = ST_DISC;
        end else if (st.imark == MK_SYN && st.rmark == MK_SYN) begin
            if (!rev && r_fin.ack && st.state == ST_CONNECTING) begin
                ns.state = ST_CONNECTED;
                n_kind   = LK_HS_ACK;
                n_lat    = lat;
            end
            ns.last  = r_fin.arrival;
            wr.en    = 1'b1;
            wr.valid = 1'b1;
            wr.st    = ns;
            n_ev     = EV_MODIFIED;
            n_cst    = ns.state;
        end else if (st.imark == MK_FIN && st.rmark == MK_FIN && r_fin.ack
                     && st.state == ST_DISCONNECTING && st.closer == my_side) begin
            wr.en    = 1'b1;
            wr.valid = 1'b0;
            wr.st    = st;
            n_ev     = EV_REMOVED;
            n_kind   = LK_FINAL_ACK;
            n_lat    = lat;
            n_cst    = ST_DISC;
        end

        slot_ext = {6'd0, wr_slot};
        n_slot   = slot_ext[5:0];
        wr.en    = wr.en && fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_RUN && c_vld[SESSIONS]) begin
            r_fin       <= c_probe[SESSIONS];
            r_fwd_slot  <= c_fwd[SESSIONS];
            r_rev_slot  <= c_rev[SESSIONS];
            r_free_slot <= c_free[SESSIONS];
        end
        if (fire) begin
            r_ev   <= n_ev;
            r_rev  <= n_rev;
            r_slot <= n_slot;
            r_cst  <= n_cst;
            r_kind <= n_kind;
            r_lat  <= n_lat;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.event_code     = r_ev;
    assign o_res.reverse_dir    = r_rev;
    assign o_res.slot_index     = r_slot;
    assign o_res.conn_state_out = r_cst;
    assign o_res.latency_kind   = r_kind;
    assign o_res.latency_us     = r_lat;
endmodule
`default_nettype wire

### tb/tcp_connection_tracker_tb.sv
// tcp_connection_tracker_tb: self-checking testbench with a session table predictor
`timescale 1ns / 1ps
`default_nettype none
module tcp_connection_tracker_tb;
    import tcpt_pkg::*;

    localparam int NSLOT = SESSIONS_DEF;

    typedef struct packed {
        logic [31:0] sip;
        logic [15:0] sport;
        logic [31:0] dip;
        logic [15:0] dport;
        logic        syn;
        logic        fin;
        logic        rst;
        logic        ack;
        logic [47:0] t;
    } t_pkt;

    typedef struct packed {
        logic [2:0]  ev;
        logic        rev;
        logic [5:0]  slot;
        logic [1:0]  state;
        logic [2:0]  kind;
        logic [47:0] lat;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcpt_in_if  pkt_if();
    tcpt_out_if res_if();

    tcp_connection_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if.sink),
        .o_res   (res_if.source)
    );

    // predictor copy of the session table
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_iip   [NSLOT];
    logic [31:0] tbl_rip   [NSLOT];
    logic [15:0] tbl_iport [NSLOT];
    logic [15:0] tbl_rport [NSLOT];
    logic [1:0]  tbl_state [NSLOT];
    logic [1:0]  tbl_imark [NSLOT];
    logic [1:0]  tbl_rmark [NSLOT];
    logic [1:0]  tbl_closer[NSLOT];
    logic [47:0] tbl_last  [NSLOT];

    t_res expected_results[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic [47:0] clock_us = 48'd1000;

    // sessions the random part keeps using
    t_pkt known_flows[$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        pkt_if.valid = 1'b0;
        pkt_if.source_ip = '0;
        pkt_if.source_port = '0;
        pkt_if.dest_ip = '0;
        pkt_if.dest_port = '0;
        pkt_if.syn_flag = 1'b0;
        pkt_if.fin_flag = 1'b0;
        pkt_if.rst_flag = 1'b0;
        pkt_if.ack_flag = 1'b0;
        pkt_if.arrival_time = '0;
        res_if.ready = 1'b0;
    end

    function automatic int find_session(logic [31:0] aip, logic [15:0] aport,
                                        logic [31:0] bip, logic [15:0] bport);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl_iip[i] == aip && tbl_iport[i] == aport &&
                tbl_rip[i] == bip && tbl_rport[i] == bport)
                return i;
        return -1;
    endfunction

    function automatic logic [47:0] elapsed(int s, logic [47:0] t);
        return (t > tbl_last[s]) ? t - tbl_last[s] : 48'd0;
    endfunction

    function automatic t_res make_res(logic [2:0] ev, logic rev, int slot,
                                      logic [1:0] st, logic [2:0] kind, logic [47:0] lat);
        t_res r;
        r.ev = ev;
        r.rev = rev;
        r.slot = slot[5:0];
        r.state = st;
        r.kind = kind;
        r.lat = lat;
        return r;
    endfunction

    function automatic t_res open_session(t_pkt p, logic [1:0] st, logic [1:0] rmark);
        for (int i = 0; i < NSLOT; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_iip[i] = p.sip;
                tbl_iport[i] = p.sport;
                tbl_rip[i] = p.dip;
                tbl_rport[i] = p.dport;
                tbl_state[i] = st;
                tbl_imark[i] = MK_SYN;
                tbl_rmark[i] = rmark;
                tbl_closer[i] = CL_NONE;
                tbl_last[i] = p.t;
                return make_res(EV_ADDED, 1'b0, i, st, LK_NONE, 48'd0);
            end
        end
        return make_res(EV_FULL, 1'b0, 0, ST_DISC, LK_NONE, 48'd0);
    endfunction

    function automatic t_res track_packet(t_pkt p);
        int f, r, s;
        logic rev;
        logic [1:0] own, other;
        logic [2:0] kind;
        logic [47:0] lat;
        f = find_session(p.sip, p.sport, p.dip, p.dport);
        r = (f < 0) ? find_session(p.dip, p.dport, p.sip, p.sport) : -1;
        s = (f >= 0) ? f : r;
        rev = (f < 0 && r >= 0);
        own = MK_NONE;
        other = MK_NONE;
        if (s >= 0) begin
            own = rev ? tbl_rmark[s] : tbl_imark[s];
            other = rev ? tbl_imark[s] : tbl_rmark[s];
        end
        if (p.syn) begin
            if (s < 0)
                return open_session(p, ST_CONNECTING, MK_NONE);
            if (own == MK_SYN)
                return make_res(EV_DUP_SYN, rev, s, tbl_state[s], LK_NONE, 48'd0);
            if (!rev) begin
                tbl_valid[s] = 1'b0;
                tbl_state[s] = ST_DISC;
                return make_res(EV_BAD_SYN, 1'b0, s, ST_DISC, LK_NONE, 48'd0);
            end
            lat = elapsed(s, p.t);
            tbl_rmark[s] = MK_SYN;
            tbl_last[s] = p.t;
            return make_res(EV_MODIFIED, 1'b1, s, tbl_state[s], LK_SYNACK, lat);
        end
        if (p.fin && s >= 0) begin
            if (own == MK_FIN)
                return make_res(EV_IGNORED, rev, s, tbl_state[s], LK_NONE, 48'd0);
            kind = (other == MK_SYN) ? LK_FIRST_FIN : LK_SECOND_FIN;
            lat = elapsed(s, p.t);
            if (rev) tbl_rmark[s] = MK_FIN;
            else tbl_imark[s] = MK_FIN;
            if (tbl_state[s] == ST_CONNECTED) begin
                tbl_state[s] = ST_DISCONNECTING;
                if (tbl_closer[s] == CL_NONE)
                    tbl_closer[s] = rev ? CL_RESPONDER : CL_INITIATOR;
            end
            tbl_last[s] = p.t;
            return make_res(EV_MODIFIED, rev, s, tbl_state[s], kind, lat);
        end
        if (p.rst && s >= 0) begin
            lat = elapsed(s, p.t);
            tbl_valid[s] = 1'b0;
            tbl_state[s] = ST_DISC;
            return make_res(EV_REMOVED, rev, s, ST_DISC, LK_FIRST_FIN, lat);
        end
        if (s < 0)
            return open_session(p, ST_CONNECTED, MK_SYN);
        if (tbl_imark[s] == MK_SYN && tbl_rmark[s] == MK_SYN) begin
            kind = LK_NONE;
            lat = 48'd0;
            if (!rev && p.ack && tbl_state[s] == ST_CONNECTING) begin
                kind = LK_HS_ACK;
                lat = elapsed(s, p.t);
                tbl_state[s] = ST_CONNECTED;
            end
            tbl_last[s] = p.t;
            return make_res(EV_MODIFIED, rev, s, tbl_state[s], kind, lat);
        end
        if (tbl_imark[s] == MK_FIN && tbl_rmark[s] == MK_FIN && p.ack &&
            tbl_state[s] == ST_DISCONNECTING &&
            tbl_closer[s] == (rev ? CL_RESPONDER : CL_INITIATOR)) begin
            lat = elapsed(s, p.t);
            tbl_valid[s] = 1'b0;
            tbl_state[s] = ST_DISC;
            return make_res(EV_REMOVED, rev, s, ST_DISC, LK_FINAL_ACK, lat);
        end
        return make_res(EV_IGNORED, rev, s, tbl_state[s], LK_NONE, 48'd0);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sends one item and records its expected result; valid drops only while idling
    task automatic send_packet(t_pkt p);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.source_ip <= p.sip;
        pkt_if.source_port <= p.sport;
        pkt_if.dest_ip <= p.dip;
        pkt_if.dest_port <= p.dport;
        pkt_if.syn_flag <= p.syn;
        pkt_if.fin_flag <= p.fin;
        pkt_if.rst_flag <= p.rst;
        pkt_if.ack_flag <= p.ack;
        pkt_if.arrival_time <= p.t;
        do @(posedge i_clk); while (!pkt_if.ready);
        expected_results.push_back(track_packet(p));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", {61'd0, res_if.event_code}, 64'd0);
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (res_if.event_code !== e.ev)
                        report_mismatch("event_code", 64'(res_if.event_code), 64'(e.ev));
                    if (res_if.reverse_dir !== e.rev)
                        report_mismatch("reverse_dir", 64'(res_if.reverse_dir), 64'(e.rev));
                    if (res_if.slot_index !== e.slot)
                        report_mismatch("slot_index", 64'(res_if.slot_index), 64'(e.slot));
                    if (res_if.conn_state_out !== e.state)
                        report_mismatch("conn_state_out", 64'(res_if.conn_state_out),
                                        64'(e.state));
                    if (res_if.latency_kind !== e.kind)
                        report_mismatch("latency_kind", 64'(res_if.latency_kind),
                                        64'(e.kind));
                    if (res_if.latency_us !== e.lat)
                        report_mismatch("latency_us", 64'(res_if.latency_us), 64'(e.lat));
                end
            end
            res_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    function automatic t_pkt flow_pkt(logic [31:0] sip, logic [15:0] sport,
                                      logic [31:0] dip, logic [15:0] dport,
                                      logic [3:0] flags, logic [47:0] t);
        t_pkt p;
        p.sip = sip;
        p.sport = sport;
        p.dip = dip;
        p.dport = dport;
        {p.syn, p.fin, p.rst, p.ack} = flags;
        p.t = t;
        return p;
    endfunction

    function automatic t_pkt flip(t_pkt p);
        t_pkt q;
        q = p;
        q.sip = p.dip;
        q.sport = p.dport;
        q.dip = p.sip;
        q.dport = p.sport;
        return q;
    endfunction

    function automatic t_pkt random_flow();
        return flow_pkt($urandom(), 16'($urandom_range(65535, 0)), $urandom(),
                        16'($urandom_range(65535, 0)), 4'b0000, 48'd0);
    endfunction

    // flag nibble order: syn fin rst ack
    localparam logic [3:0] FL_SYN = 4'b1000;
    localparam logic [3:0] FL_FIN = 4'b0100;
    localparam logic [3:0] FL_RST = 4'b0010;
    localparam logic [3:0] FL_ACK = 4'b0001;

    task automatic send_on(t_pkt flow, logic reverse, logic [3:0] flags, logic [47:0] t);
        t_pkt p;
        p = reverse ? flip(flow) : flow;
        {p.syn, p.fin, p.rst, p.ack} = flags;
        p.t = t;
        send_packet(p);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        pkt_if.valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic test_directed_lifecycle();
        t_pkt a, b;
        a = flow_pkt(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 16'h0000, 4'b0, 48'd0);
        b = flow_pkt(32'h0A00_0001, 16'd80, 32'h0A00_0002, 16'd1234, 4'b0, 48'd0);
        // full handshake and initiator-first close
        send_on(a, 1'b0, FL_SYN, 48'd100);
        send_on(a, 1'b0, FL_SYN, 48'd110);
        send_on(a, 1'b1, FL_SYN | FL_ACK, 48'd150);
        send_on(a, 1'b1, FL_SYN, 48'd160);
        send_on(a, 1'b0, FL_ACK, 48'd170);
        send_on(a, 1'b1, FL_ACK, 48'd175);
        send_on(a, 1'b0, FL_FIN | FL_ACK, 48'd50);
        send_on(a, 1'b0, FL_FIN, 48'd300);
        send_on(a, 1'b1, FL_FIN | FL_ACK, 48'd400);
        send_on(a, 1'b1, FL_ACK, 48'd410);
        send_on(a, 1'b0, FL_ACK, 48'hFFFF_FFFF_FFFF);
        // repeated syn from the initiator on an open session is a duplicate
        send_on(b, 1'b0, 4'b0000, 48'd0);
        send_on(b, 1'b0, FL_SYN, 48'd5);
        // mid-stream fin and rst
        send_on(b, 1'b1, FL_FIN | FL_RST, 48'd7);
        send_on(b, 1'b1, FL_RST, 48'd9);
        send_on(b, 1'b0, FL_FIN | FL_RST | FL_ACK | FL_SYN, 48'd11);
        send_on(b, 1'b1, FL_RST, 48'd3);
        wait_drained();
    endtask

    task automatic test_table_full();
        t_pkt f;
        // fill every slot with mid-stream sessions, then overflow
        for (int i = 0; i < NSLOT + 2; i++) begin
            f = flow_pkt(32'hC0A8_0000 + i, 16'(i), 32'h0808_0808, 16'd443, 4'b0, 48'd0);
            send_on(f, 1'b0, FL_ACK, clock_us);
        end
        for (int i = 0; i < NSLOT; i++) begin
            f = flow_pkt(32'hC0A8_0000 + i, 16'(i), 32'h0808_0808, 16'd443, 4'b0, 48'd0);
            send_on(f, i[0], FL_RST, clock_us + 1);
        end
        wait_drained();
    endtask

    task automatic random_phase(int items, int idle, int stall);
        t_pkt flow;
        int k, pick;
        logic rv;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < items; n++) begin
            clock_us = clock_us + $urandom_range(500, 0);
            if ($urandom_range(99, 0) < 5)
                clock_us = clock_us - $urandom_range(300, 0);
            if (n % 60 == 59)
                clock_us = {$urandom(), 16'($urandom())};
            k = $urandom_range(99, 0);
            if (known_flows.size() < 8 || k < 12) begin
                flow = random_flow();
                if ($urandom_range(3, 0) == 0)
                    flow.dip = flow.sip;
                known_flows.push_back(flow);
                if (known_flows.size() > 24) void'(known_flows.pop_front());
                send_on(flow, 1'b0, ($urandom_range(3, 0) != 0) ? FL_SYN : 4'($urandom()),
                        clock_us);
            end else if (k < 85) begin
                pick = $urandom_range(known_flows.size() - 1, 0);
                flow = known_flows[pick];
                rv = 1'($urandom_range(1, 0));
                case ($urandom_range(5, 0))
                    0: send_on(flow, 1'b1, FL_SYN | FL_ACK, clock_us);
                    1: send_on(flow, 1'b0, FL_ACK, clock_us);
                    2: send_on(flow, rv, FL_FIN | FL_ACK, clock_us);
                    3: send_on(flow, rv, FL_ACK, clock_us);
                    4: send_on(flow, rv, ($urandom_range(4, 0) == 0) ? FL_RST : FL_ACK,
                               clock_us);
                    default: send_on(flow, rv, 4'($urandom()), clock_us);
                endcase
            end else begin
                flow = random_flow();
                send_on(flow, 1'($urandom_range(1, 0)), 4'($urandom()), clock_us);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_state[i] = ST_DISC;
        end
        @(posedge i_clk);
        test_directed_lifecycle();
        test_table_full();
        random_phase(180, 0, 0);
        random_phase(170, 78, 0);
        random_phase(170, 0, 78);
        random_phase(180, 36, 36);
        if (expected_results.size() != 0)
            errors += expected_results.size();
        if (errors == 0)
            $display("tcp_connection_tracker test passed");
        else
            $display("tcp_connection_tracker test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tcp_connection_tracker test failed");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
hw/rtl/tcpt_pkg.sv
hw/rtl/tcpt_if.sv
hw/rtl/tcpt_cell.sv
hw/rtl/tcp_connection_tracker.sv
tb/tcp_connection_tracker_tb.sv
